### design/pvr_pkg.sv
// ----------------------------------------------------------------------------
// pvr_pkg
// Shared types and codes for the plot row mapper.
// ----------------------------------------------------------------------------
package pvr_pkg;

	typedef enum logic [1:0] {
		CFG_RANGE_MIN  = 2'd0,
		CFG_RANGE_MAX  = 2'd1,
		CFG_TOP_ROW    = 2'd2,
		CFG_BOTTOM_ROW = 2'd3
	} cfg_index_t;

	localparam int CFG_INDEX_BITS = 2;

endpackage

### design/plot_value_to_row.sv
// ----------------------------------------------------------------------------
// plot_value_to_row
// Maps a signed sample onto a pixel row between the configured top and
// bottom rows, with clamping and round-half-up scaling.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled. Each
// item passes a clamp stage, a multiply stage, the restoring divider, which
// resolves one quotient bit per pipeline stage, and the output register.
// A stalled output holds its item, and empty stages still fill, so input is
// taken while earlier rows wait.
module plot_value_to_row
	import pvr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int ROW_BITS    = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((ROW_BITS+7)/8)*8-1:0]      m_tdata,   // row
	input  logic                               wr_en,
	input  logic [CFG_INDEX_BITS-1:0]          wr_index,
	input  logic [((SAMPLE_BITS > ROW_BITS) ? SAMPLE_BITS : ROW_BITS)-1:0] wr_data
);

	localparam int S  = SAMPLE_BITS;
	localparam int R  = ROW_BITS;
	localparam int W  = S + R;
	localparam int OW = ((R + 7) / 8) * 8;

	logic signed [S-1:0] range_min_q, range_max_q;
	logic signed [R-1:0] top_row_q, bottom_row_q;
	logic [S-1:0]        span_q;
	logic [R-1:0]        height_q;
	logic                ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q  <= '0;
			range_max_q  <= '0;
			top_row_q    <= '0;
			bottom_row_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_RANGE_MIN:  range_min_q  <= wr_data[S-1:0];
				CFG_RANGE_MAX:  range_max_q  <= wr_data[S-1:0];
				CFG_TOP_ROW:    top_row_q    <= wr_data[R-1:0];
				CFG_BOTTOM_ROW: bottom_row_q <= wr_data[R-1:0];
				default: ;
			endcase
		end
	end

	logic [S:0] span_full;
	logic [R:0] height_full;
	assign span_full   = {range_max_q[S-1], range_max_q} - {range_min_q[S-1], range_min_q};
	assign height_full = {bottom_row_q[R-1], bottom_row_q} - {top_row_q[R-1], top_row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= '0;
			height_q <= '0;
			ok_q     <= 1'b0;
		end else begin
			span_q   <= span_full[S-1:0];
			height_q <= height_full[R-1:0];
			ok_q     <= (range_max_q > range_min_q) && (bottom_row_q > top_row_q);
		end
	end

	// Handshake enables, from the output back to the input.
	logic vld_s1, vld_s2, vld_out_s;
	logic en_s1, en_s2, en_out;
	logic div_vld_s [R];
	logic div_en [R];

	assign en_out = !vld_out_s || m_tready;
	assign div_en[R-1] = !div_vld_s[R-1] || en_out;
	for (genvar k = 0; k < R - 1; k++) begin : g_en
		assign div_en[k] = !div_vld_s[k] || div_en[k+1];
	end
	assign en_s2 = !vld_s2 || div_en[0];
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	// Stage 1: clamp the sample into the range and take its offset.
	logic signed [S-1:0] sample;
	logic signed [S-1:0] clamped;
	logic [S:0]          delta_full;
	logic [S-1:0]        delta_s1;

	assign sample     = s_tdata[S-1:0];
	assign clamped    = (sample < range_min_q) ? range_min_q :
	                    (sample > range_max_q) ? range_max_q : sample;
	assign delta_full = {clamped[S-1], clamped} - {range_min_q[S-1], range_min_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			delta_s1 <= delta_full[S-1:0];
		end
	end

	// Stage 2: scale by the height and add half the span for rounding.
	logic [W-1:0] num_s2;
	logic [W-1:0] product;
	assign product = {{R{1'b0}}, delta_s1} * {{S{1'b0}}, height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			num_s2 <= product + {{(R + 1){1'b0}}, span_q[S-1:1]};
		end
	end

	// Restoring division, one quotient bit per stage.
	logic [S-1:0] div_rem_s [R];
	logic [R-1:0] div_low_s [R];
	logic [R-1:0] div_quo_s [R];

	for (genvar k = 0; k < R; k++) begin : g_div
		logic [S-1:0] rem_in;
		logic [R-1:0] low_in;
		logic [R-1:0] quo_in;
		logic         vld_in;
		logic [S:0]   trial;
		logic         fits;
		logic [S:0]   reduced;

		if (k == 0) begin : g_first
			assign rem_in = num_s2[W-1:R];
			assign low_in = num_s2[R-1:0];
			assign quo_in = '0;
			assign vld_in = vld_s2;
		end else begin : g_next
			assign rem_in = div_rem_s[k-1];
			assign low_in = div_low_s[k-1];
			assign quo_in = div_quo_s[k-1];
			assign vld_in = div_vld_s[k-1];
		end

		assign trial   = {rem_in, low_in[R-1]};
		assign fits    = trial >= {1'b0, span_q};
		assign reduced = fits ? (trial - {1'b0, span_q}) : trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (div_en[k]) begin
				div_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (div_en[k]) begin
				div_rem_s[k] <= reduced[S-1:0];
				div_low_s[k] <= {low_in[R-2:0], 1'b0};
				div_quo_s[k] <= {quo_in[R-2:0], fits};
			end
		end
	end

	// Output register.
	logic signed [R-1:0] row_out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (en_out) begin
			vld_out_s <= div_vld_s[R-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			row_out_s <= ok_q ? (bottom_row_q - div_quo_s[R-1]) : bottom_row_q;
		end
	end

	assign m_tvalid = vld_out_s;
	assign m_tdata  = {{(OW - R){1'b0}}, row_out_s};

	a_row_in_plot: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_out_s && ok_q) |-> (row_out_s <= bottom_row_q && row_out_s >= top_row_q))
		else $error("row outside the plot rows");

	a_row_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_out_s && !ok_q) |-> (row_out_s == bottom_row_q))
		else $error("degenerate setup did not give the bottom row");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld_s[R-1] && ok_q) |-> (div_rem_s[R-1] < span_q))
		else $error("division remainder not below the span");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input stalled with an empty first stage");

endmodule
